// ----- design/fat16cs_pkg.sv -----
// Shared types and constants for the FAT16 cluster chain sector sequencer.
package fat16cs_pkg;

  localparam int unsigned CLUSTER_W = 32;
  localparam int unsigned LBA_W     = 32;
  localparam int unsigned WIDX_W    = 8;
  localparam int unsigned DEST_W    = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned OUT_DAT_W = LBA_W + WIDX_W + DEST_W;

  localparam logic [CLUSTER_W-1:0] END_MARKER  = 32'h0000_FFF8;
  localparam logic [CLUSTER_W-1:0] FIRST_VALID = 32'd2;
  localparam logic [DEST_W-1:0]    DEST_MAX    = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA = 2'd0,
    KIND_FAT  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_LINK  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESERVED_SECTORS = 3'd0,
    REG_FAT_COPIES       = 3'd1,
    REG_SECTORS_PER_FAT  = 3'd2,
    REG_ROOT_ENTRIES     = 3'd3,
    REG_SECTOR_BYTES     = 3'd4,
    REG_CLUSTER_SECTORS  = 3'd5
  } reg_idx_t;

endpackage

// ----- design/fat16_cluster_chain_sector_sequencer_unit.sv -----
// FAT16 cluster chain walker: turns one cluster number into sector read requests.
//
// Usage: configure the volume layout on the cfg channel (index 0..5: reserved
// sectors, FAT copies, sectors per FAT, root entries, sector bytes, cluster
// sectors) while idle. Send one word per cluster on the s_ channel: tuser 0
// starts a file and clears the destination sector counter, tuser 1 gives the
// FAT word read back for the next link. Each cluster yields one data read word
// per sector of the cluster, then a FAT read word with the word index of the
// next link; tlast marks the final word. End markers give one done word,
// clusters 0 and 1 one bad word.
// Sequence: after the accept a normal cluster passes through setup (two
// multiplies and three adds on one shared multiplier and adder, 16 steps of a
// bit-serial divider for the root directory size), then one word per cycle
// while m_tready is high, cluster_sectors + 1 words. End and bad clusters skip the setup.
// s_tready is high only while the sequencer is idle; a new word may be taken
// while the last result still waits in the output register.
// Reset restores the default layout (512-byte sectors, 2 FATs of 1 sector,
// 512 root entries, 4 sectors per cluster), clears the counter and drops
// m_tvalid. A stalled receiver holds the output word and pauses the sequencer.
module fat16_cluster_chain_sector_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fat16cs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fat16cs_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fat16cs_pkg::CLUSTER_W-1:0] s_tdata,  // cluster
  input  logic                              s_tuser,  // op
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [fat16cs_pkg::OUT_DAT_W-1:0] m_tdata,  // lba, fat_word_index, dest_sector
  output logic [fat16cs_pkg::KIND_W-1:0]    m_tuser,  // kind
  output logic                              m_tlast
);
  import fat16cs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_ADD1, S_DIV, S_ADD2, S_MUL2, S_ADD3,
    S_DATA, S_FAT, S_END, S_BAD
  } state_t;

  state_t            state;
  logic [15:0]       reserved_sectors;
  logic [7:0]        fat_copies;
  logic [15:0]       sectors_per_fat;
  logic [15:0]       root_entries;
  logic [12:0]       sector_bytes;
  logic [5:0]        cluster_sectors;
  logic [DEST_W-1:0] dest_count;
  logic [CLUSTER_W-1:0] cl;
  logic [LBA_W-1:0]  acc;
  logic [LBA_W-1:0]  prod;
  logic [15:0]       quo;
  logic [7:0]        rem;
  logic [3:0]        div_cnt;
  logic [5:0]        idx;

  logic [7:0]        divisor;
  logic [8:0]        rem_sh;
  logic              rem_ge;
  logic [31:0]       mul_a;
  logic [15:0]       mul_b;
  logic [47:0]       mul_p;
  logic [LBA_W-1:0]  add_a;
  logic [LBA_W-1:0]  add_b;
  logic [LBA_W-1:0]  add_s;
  logic              out_free;
  logic              out_load;
  logic              s_acc;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && (state == S_DATA || state == S_FAT ||
                                  state == S_END || state == S_BAD);

  assign divisor = sector_bytes[12:5];
  assign rem_sh  = {rem, quo[15]};
  assign rem_ge  = (rem_sh >= {1'b0, divisor});

  always_comb begin
    mul_a = {24'd0, fat_copies};
    mul_b = sectors_per_fat;
    if (state == S_MUL2) begin
      mul_a = cl - FIRST_VALID;
      mul_b = {10'd0, cluster_sectors};
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    add_a = acc;
    add_b = 32'd1;
    unique case (state)
      S_ADD1: begin
        add_a = prod;
        add_b = {16'd0, reserved_sectors};
      end
      S_ADD2: add_b = (divisor == 8'd0) ? 32'd0 : {16'd0, quo};
      S_ADD3: add_b = prod;
      S_FAT: begin
        add_a = {16'd0, reserved_sectors};
        add_b = {8'd0, cl[31:8]};
      end
      default: ;
    endcase
  end
  assign add_s = add_a + add_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_sectors <= 16'd1;
      fat_copies       <= 8'd2;
      sectors_per_fat  <= 16'd1;
      root_entries     <= 16'd512;
      sector_bytes     <= 13'd512;
      cluster_sectors  <= 6'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RESERVED_SECTORS: reserved_sectors <= cfg_data;
        REG_FAT_COPIES:       fat_copies       <= cfg_data[7:0];
        REG_SECTORS_PER_FAT:  sectors_per_fat  <= cfg_data;
        REG_ROOT_ENTRIES:     root_entries     <= cfg_data;
        REG_SECTOR_BYTES:     sector_bytes     <= cfg_data[12:0];
        REG_CLUSTER_SECTORS:  cluster_sectors  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dest_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            cl <= s_tdata;
            if (s_tuser == OP_START) dest_count <= '0;
            if (s_tdata >= END_MARKER)      state <= S_END;
            else if (s_tdata < FIRST_VALID) state <= S_BAD;
            else                            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod  <= mul_p[LBA_W-1:0];
          state <= S_ADD1;
        end
        S_ADD1: begin
          acc     <= add_s;
          quo     <= root_entries;
          rem     <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= rem_ge ? 8'(rem_sh - {1'b0, divisor}) : rem_sh[7:0];
          quo     <= {quo[14:0], rem_ge};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) state <= S_ADD2;
        end
        S_ADD2: begin
          acc   <= add_s;
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod  <= mul_p[LBA_W-1:0];
          state <= S_ADD3;
        end
        S_ADD3: begin
          acc   <= add_s;
          idx   <= '0;
          state <= (cluster_sectors == 6'd0) ? S_FAT : S_DATA;
        end
        S_DATA: begin
          if (out_free) begin
            m_tuser  <= KIND_DATA;
            m_tlast  <= 1'b0;
            m_tdata  <= {dest_count, 8'd0, acc};
            acc      <= add_s;
            if (dest_count != DEST_MAX) dest_count <= dest_count + 16'd1;
            idx      <= idx + 6'd1;
            if (idx == cluster_sectors - 6'd1) state <= S_FAT;
          end
        end
        S_FAT: begin
          if (out_free) begin
            m_tuser  <= KIND_FAT;
            m_tlast  <= 1'b1;
            m_tdata  <= {16'd0, cl[7:0], add_s};
            state    <= S_IDLE;
          end
        end
        S_END: begin
          if (out_free) begin
            m_tuser  <= KIND_DONE;
            m_tlast  <= 1'b1;
            m_tdata  <= {dest_count, 8'd0, 32'd0};
            state    <= S_IDLE;
          end
        end
        S_BAD: begin
          if (out_free) begin
            m_tuser  <= KIND_BAD;
            m_tlast  <= 1'b1;
            m_tdata  <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tuser == OP_START |=> dest_count == '0)
    else $error("dest counter not cleared on start");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !s_acc |=> dest_count >= $past(dest_count))
    else $error("dest counter went down without start");

  a_data_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_DATA |-> !m_tlast)
    else $error("data read marked last");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_tready)
    else $error("sequencer ready right after accept");

endmodule
